[design/content_length_frame_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Content-length frame decoder assertion macros
// Shared property wrappers for the checker of the frame decoder.
// ----------------------------------------------------------------------------
`ifndef CONTENT_LENGTH_FRAME_DECODER_DEFINES_SVH
`define CONTENT_LENGTH_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CLFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clfd check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define CLFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clfd check failed: next-cycle rule");

`endif

[design/clfd_pkg.sv]
// ----------------------------------------------------------------------------
// Content-length frame decoder package
// Result codes, the token passed from parser to output stage, and defaults.
// ----------------------------------------------------------------------------
package clfd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam logic [31:0] MAX_FRAME_LENGTH_RESET = 32'd16777216;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_NO_LEN   = 2'd2;
    localparam logic [1:0] KIND_BAD_LEN  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] length;
    } clfd_token_t;

endpackage

[design/clfd_front.sv]
// ----------------------------------------------------------------------------
// Content-length frame decoder parser
// Accepts one stream byte per cycle while the queue has room, tracks the
// header block and payload, and pushes one token per result into the queue.
// ----------------------------------------------------------------------------
module clfd_front #(
    parameter int LENGTH_BITS = clfd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_stream_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output clfd_pkg::clfd_token_t push_token
);
    import clfd_pkg::*;

    localparam int CW = (LENGTH_BITS + 4 > 32) ? LENGTH_BITS + 4 : 32;
    localparam logic [3:0] KEY_LEN = 4'd14;
    localparam logic [3:0] KEY_POS_MAX = 4'd15;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] TT_NONE   = 3'd0;
    localparam logic [2:0] TT_CR     = 3'd1;
    localparam logic [2:0] TT_LF     = 3'd2;
    localparam logic [2:0] TT_CRLF   = 3'd3;
    localparam logic [2:0] TT_CRLFCR = 3'd4;

    localparam logic [1:0] LP_KEY   = 2'd0;
    localparam logic [1:0] LP_VALUE = 2'd1;
    localparam logic [1:0] LP_REST  = 2'd2;

    localparam logic [1:0] VP_BLANKS = 2'd0;
    localparam logic [1:0] VP_DIGITS = 2'd1;
    localparam logic [1:0] VP_AFTER  = 2'd2;

    typedef enum logic [1:0] {
        ST_HEADER = 2'b01,
        ST_BODY   = 2'b10
    } state_t;

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    state_t                 state_reg, state_next;
    logic [2:0]             term_reg, term_next;
    logic [1:0]             line_part_reg, line_part_next;
    logic [3:0]             key_pos_reg, key_pos_next;
    logic                   key_mis_reg, key_mis_next;
    logic [1:0]             value_phase_reg, value_phase_next;
    logic                   found_reg, found_next;
    logic                   bad_reg, bad_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [31:0]            max_len_reg;

    logic                   accept;
    logic                   is_digit;
    logic                   is_blank;
    logic                   do_acc;
    logic                   done;
    logic                   body_last;
    logic [7:0]             low_ch;
    logic [CW-1:0]          mask_w;
    logic [CW-1:0]          limit_w;
    logic [CW-1:0]          acc_w;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    assign is_digit = (s_stream_byte >= "0") && (s_stream_byte <= "9");
    assign is_blank = (s_stream_byte == 8'h20) || (s_stream_byte == 8'h09) ||
                      (s_stream_byte == CH_CR) || (s_stream_byte == 8'h0B) ||
                      (s_stream_byte == 8'h0C);
    assign low_ch   = ((s_stream_byte >= "A") && (s_stream_byte <= "Z")) ?
                      s_stream_byte + 8'd32 : s_stream_byte;

    assign mask_w  = CW'({LENGTH_BITS{1'b1}});
    assign limit_w = (CW'(max_len_reg) > mask_w) ? mask_w : CW'(max_len_reg);
    assign acc_w   = (CW'(acc_reg) << 3) + (CW'(acc_reg) << 1) + CW'(s_stream_byte[3:0]);

    assign body_last = (remain_reg <= LENGTH_BITS'(1));

    always_comb begin
        state_next       = state_reg;
        term_next        = term_reg;
        line_part_next   = line_part_reg;
        key_pos_next     = key_pos_reg;
        key_mis_next     = key_mis_reg;
        value_phase_next = value_phase_reg;
        found_next       = found_reg;
        bad_next         = bad_reg;
        acc_next         = acc_reg;
        remain_next      = remain_reg;
        do_acc           = 1'b0;
        done             = 1'b0;
        push_valid       = 1'b0;
        push_token.kind   = KIND_PAYLOAD;
        push_token.data   = s_stream_byte;
        push_token.last   = 1'b0;
        push_token.length = 32'(acc_reg);

        if (state_reg == ST_BODY) begin
            push_valid      = accept;
            push_token.last = body_last;
            if (body_last) begin
                state_next = ST_HEADER;
                acc_next   = '0;
                remain_next = '0;
            end else begin
                remain_next = remain_reg - LENGTH_BITS'(1);
            end
        end else begin
            // header lines are ignored once the length is decided
            if (!(found_reg || bad_reg)) begin
                if (s_stream_byte == CH_LF) begin
                    if (line_part_reg == LP_VALUE && value_phase_reg != VP_BLANKS) begin
                        found_next = 1'b1;
                    end
                    line_part_next   = LP_KEY;
                    key_pos_next     = '0;
                    key_mis_next     = 1'b0;
                    value_phase_next = VP_BLANKS;
                end else if (line_part_reg == LP_KEY) begin
                    if (s_stream_byte == CH_COLON) begin
                        line_part_next = (!key_mis_reg && key_pos_reg == KEY_LEN) ?
                                         LP_VALUE : LP_REST;
                    end else begin
                        if (key_pos_reg >= KEY_LEN || low_ch != key_char(key_pos_reg)) begin
                            key_mis_next = 1'b1;
                        end
                        if (key_pos_reg < KEY_POS_MAX) begin
                            key_pos_next = key_pos_reg + 4'd1;
                        end
                    end
                end else if (line_part_reg == LP_VALUE) begin
                    case (value_phase_reg)
                        VP_BLANKS: begin
                            if (!is_blank) begin
                                if (!is_digit) begin
                                    bad_next = 1'b1;
                                end else begin
                                    value_phase_next = VP_DIGITS;
                                    do_acc           = 1'b1;
                                end
                            end
                        end
                        VP_DIGITS: begin
                            if (is_digit) begin
                                do_acc = 1'b1;
                            end else begin
                                value_phase_next = VP_AFTER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (do_acc) begin
                    acc_next = LENGTH_BITS'(acc_w);
                    if (acc_w > limit_w) begin
                        bad_next = 1'b1;
                    end
                end
            end

            // header block terminator: LF LF, CR LF LF or CR LF CR LF
            if (s_stream_byte == CH_LF) begin
                if (term_reg == TT_LF || term_reg == TT_CRLF || term_reg == TT_CRLFCR) begin
                    done = 1'b1;
                end else begin
                    term_next = (term_reg == TT_CR) ? TT_CRLF : TT_LF;
                end
            end else if (s_stream_byte == CH_CR) begin
                term_next = (term_reg == TT_CRLF) ? TT_CRLFCR : TT_CR;
            end else begin
                term_next = TT_NONE;
            end

            if (done) begin
                push_token.data = 8'h00;
                if (bad_next) begin
                    push_valid      = accept;
                    push_token.kind = KIND_BAD_LEN;
                end else if (!found_next) begin
                    push_valid      = accept;
                    push_token.kind = KIND_NO_LEN;
                end else if (acc_next == '0) begin
                    push_valid      = accept;
                    push_token.kind = KIND_EMPTY;
                    push_token.last = 1'b1;
                end else begin
                    state_next  = ST_BODY;
                    remain_next = acc_next;
                end
                term_next        = TT_NONE;
                line_part_next   = LP_KEY;
                key_pos_next     = '0;
                key_mis_next     = 1'b0;
                value_phase_next = VP_BLANKS;
                found_next       = 1'b0;
                bad_next         = 1'b0;
                if (state_next != ST_BODY) begin
                    acc_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_HEADER;
            term_reg        <= TT_NONE;
            line_part_reg   <= LP_KEY;
            key_pos_reg     <= '0;
            key_mis_reg     <= 1'b0;
            value_phase_reg <= VP_BLANKS;
            found_reg       <= 1'b0;
            bad_reg         <= 1'b0;
            acc_reg         <= '0;
            remain_reg      <= '0;
            max_len_reg     <= MAX_FRAME_LENGTH_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept) begin
                state_reg       <= state_next;
                term_reg        <= term_next;
                line_part_reg   <= line_part_next;
                key_pos_reg     <= key_pos_next;
                key_mis_reg     <= key_mis_next;
                value_phase_reg <= value_phase_next;
                found_reg       <= found_next;
                bad_reg         <= bad_next;
                acc_reg         <= acc_next;
                remain_reg      <= remain_next;
            end
        end
    end

endmodule

[design/clfd_queue.sv]
// ----------------------------------------------------------------------------
// Content-length frame decoder token queue
// Two-entry queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module clfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  clfd_pkg::clfd_token_t push_token,
    output logic                  pop_valid,
    input  logic                  pop_en,
    output clfd_pkg::clfd_token_t pop_token
);
    import clfd_pkg::*;

    clfd_token_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_token  = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_en && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

[design/clfd_back.sv]
// ----------------------------------------------------------------------------
// Content-length frame decoder output stage
// Pops tokens, formats the result fields by kind and holds them for the sink.
// ----------------------------------------------------------------------------
module clfd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_en,
    input  clfd_pkg::clfd_token_t pop_token,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [7:0]            m_payload_byte,
    output logic                  m_frame_last,
    output logic [31:0]           m_frame_length
);
    import clfd_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] length_reg;
    logic        load;
    logic        is_payload;
    logic        has_length;

    // advance whenever the output register is empty or being taken
    assign load   = pop_valid && (!valid_reg || m_ready);
    assign pop_en = load;

    assign is_payload = (pop_token.kind == KIND_PAYLOAD);
    assign has_length = is_payload || (pop_token.kind == KIND_EMPTY);

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= pop_token.kind;
            byte_reg   <= is_payload ? pop_token.data : 8'h00;
            last_reg   <= is_payload ? pop_token.last : (pop_token.kind == KIND_EMPTY);
            length_reg <= has_length ? pop_token.length : 32'd0;
        end
    end

    assign m_valid        = valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_payload_byte = byte_reg;
    assign m_frame_last   = last_reg;
    assign m_frame_length = length_reg;

endmodule

[design/content_length_frame_decoder.sv]
// ----------------------------------------------------------------------------
// Content-length frame decoder
// Splits a byte stream into header blocks and content-length sized payloads.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle, back to back, while the token queue has
// room, and gives at most one result per byte: each payload byte with a last
// mark, one empty-frame result for a zero length, or one drop report when a
// header block ends without a usable length or with a bad one. The rate is
// set by the parser's length accumulate-and-compare path, which runs once per
// byte. A two-entry token queue and an output register sit between parser and
// sink, so a stalled sink does not stop the stream until the queue fills. A
// result enters the queue as its byte is accepted and then waits in the
// output register for the sink. The user must write max_frame_length through
// cfg_wr_en / cfg_wr_data only while the block is idle; it is not enforced.
module content_length_frame_decoder #(
    parameter int LENGTH_BITS = clfd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_last,
    output logic [31:0] m_frame_length
);
    import clfd_pkg::*;

    logic        push_valid;
    logic        push_ready;
    clfd_token_t push_token;
    logic        pop_valid;
    logic        pop_en;
    clfd_token_t pop_token;

    clfd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_token    (push_token)
    );

    clfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_token (push_token),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_token  (pop_token)
    );

    clfd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_en         (pop_en),
        .pop_token      (pop_token),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_last   (m_frame_last),
        .m_frame_length (m_frame_length)
    );

endmodule

[design/clfd_checker.sv]
// ----------------------------------------------------------------------------
// Content-length frame decoder checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "content_length_frame_decoder_defines.svh"

module clfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [31:0] cfg_wr_data,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_stream_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_result_kind,
    input logic [7:0]  m_payload_byte,
    input logic        m_frame_last,
    input logic [31:0] m_frame_length
);
    import clfd_pkg::*;

    // hold a stalled result
    `CLFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_kind) && $stable(m_payload_byte) && $stable(m_frame_length))
    // drop reports carry no byte, length or last mark
    `CLFD_ASSERT_NOW(a_drop_clean, aclk, aresetn, m_valid && (m_result_kind == KIND_NO_LEN || m_result_kind == KIND_BAD_LEN), m_payload_byte == 8'h00 && !m_frame_last && m_frame_length == 32'd0)
    // an empty frame is marked last and has zero length
    `CLFD_ASSERT_NOW(a_empty_frame, aclk, aresetn, m_valid && m_result_kind == KIND_EMPTY, m_frame_last && m_frame_length == 32'd0 && m_payload_byte == 8'h00)
    // payload only follows a nonzero length
    `CLFD_ASSERT_NOW(a_payload_len, aclk, aresetn, m_valid && m_result_kind == KIND_PAYLOAD, m_frame_length != 32'd0)

endmodule

bind content_length_frame_decoder clfd_checker u_clfd_checker (.*);

[dv/tb_content_length_frame_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Content-length frame decoder testbench
// Streams header blocks and payloads into the decoder under random idle and
// stall gaps, predicts each result byte by byte and checks every field.
// ----------------------------------------------------------------------------
module tb_content_length_frame_decoder;
    import clfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_BYTES   = 20;
    localparam int KEY_LEN       = 14;

    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_VT      = 8'h0B;
    localparam logic [7:0] BYTE_FF      = 8'h0C;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_ZERO    = 8'h30;
    localparam logic [7:0] BYTE_NINE    = 8'h39;
    localparam logic [7:0] BYTE_COLON   = 8'h3A;
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;

    typedef enum logic [2:0] {
        TRK_NONE, TRK_CR, TRK_LF, TRK_CR_LF, TRK_CR_LF_CR
    } term_state_e;
    typedef enum logic [1:0] {LINE_KEY, LINE_VALUE, LINE_SKIP} line_part_e;
    typedef enum logic [1:0] {VAL_BLANKS, VAL_DIGITS, VAL_AFTER} value_phase_e;

    class frame_tracker;
        logic [31:0]  max_len;
        bit           in_body;
        term_state_e  term;
        line_part_e   part;
        int unsigned  key_pos;
        bit           key_bad;
        value_phase_e vphase;
        bit           len_found;
        bit           len_bad;
        logic [63:0]  len_acc;
        logic [63:0]  body_left;
        clfd_token_t  due_tokens[$];
        int           mismatches;
        string        key_text;

        function new();
            key_text   = "content-length";
            max_len    = MAX_FRAME_LENGTH_RESET;
            mismatches = 0;
            restart_header();
        endfunction

        function void restart_line();
            part    = LINE_KEY;
            key_pos = 0;
            key_bad = 0;
            vphase  = VAL_BLANKS;
        endfunction

        function void restart_header();
            in_body   = 0;
            term      = TRK_NONE;
            restart_line();
            len_found = 0;
            len_bad   = 0;
            len_acc   = '0;
            body_left = '0;
        endfunction

        function void note_due(clfd_token_t tok);
            due_tokens = {due_tokens, tok};
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == BYTE_SPACE || c == BYTE_TAB || c == BYTE_CR ||
                   c == BYTE_VT || c == BYTE_FF;
        endfunction

        function void scan_line(logic [7:0] c);
            logic [7:0] low;
            bit         digit;
            // the header is decided once a length is taken or found bad
            if (len_found || len_bad) return;
            if (c == BYTE_LF) begin
                if (part == LINE_VALUE && vphase != VAL_BLANKS) len_found = 1;
                restart_line();
                return;
            end
            digit = (c >= BYTE_ZERO && c <= BYTE_NINE);
            case (part)
                LINE_KEY: begin
                    if (c == BYTE_COLON) begin
                        part = (!key_bad && key_pos == KEY_LEN) ? LINE_VALUE : LINE_SKIP;
                        return;
                    end
                    low = (c >= BYTE_UPPER_A && c <= BYTE_UPPER_Z) ? c + 8'd32 : c;
                    if (key_pos >= KEY_LEN || low != key_text[key_pos]) key_bad = 1;
                    if (key_pos < 15) key_pos++;
                end
                LINE_VALUE: begin
                    if (vphase == VAL_BLANKS) begin
                        if (is_blank(c)) return;
                        if (!digit) begin
                            len_bad = 1;
                            return;
                        end
                        vphase = VAL_DIGITS;
                    end else if (vphase == VAL_AFTER || !digit) begin
                        vphase = VAL_AFTER;
                        return;
                    end
                    len_acc = len_acc * 10 + (c - BYTE_ZERO);
                    if (len_acc > {32'd0, max_len}) len_bad = 1;
                end
                default: ;
            endcase
        endfunction

        function bit end_of_header(logic [7:0] c);
            if (c == BYTE_LF) begin
                if (term == TRK_LF || term == TRK_CR_LF || term == TRK_CR_LF_CR) return 1;
                term = (term == TRK_CR) ? TRK_CR_LF : TRK_LF;
            end else if (c == BYTE_CR) begin
                term = (term == TRK_CR_LF) ? TRK_CR_LF_CR : TRK_CR;
            end else begin
                term = TRK_NONE;
            end
            return 0;
        endfunction

        function void take_byte(logic [7:0] c);
            clfd_token_t tok;
            logic [63:0] len;
            tok = '0;
            if (in_body) begin
                tok.kind   = KIND_PAYLOAD;
                tok.data   = c;
                tok.last   = (body_left <= 1);
                tok.length = len_acc[31:0];
                note_due(tok);
                if (body_left <= 1) restart_header();
                else body_left--;
                return;
            end
            scan_line(c);
            if (!end_of_header(c)) return;
            if (len_bad) begin
                tok.kind = KIND_BAD_LEN;
            end else if (!len_found) begin
                tok.kind = KIND_NO_LEN;
            end else if (len_acc == 0) begin
                tok.kind = KIND_EMPTY;
                tok.last = 1;
            end else begin
                // enter the payload; no result until its first byte
                len = len_acc;
                restart_header();
                in_body   = 1;
                len_acc   = len;
                body_left = len;
                return;
            end
            note_due(tok);
            restart_header();
        endfunction

        task report_mismatch(string what);
            $display("tb: mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task match_result(logic [1:0] kind, logic [7:0] data, logic last,
                          logic [31:0] length);
            clfd_token_t want;
            if (due_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h", kind, data));
                return;
            end
            want = due_tokens.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("result_kind %0d, want %0d", kind, want.kind));
            if (data !== want.data)
                report_mismatch($sformatf("payload_byte %02h, want %02h", data, want.data));
            if (last !== want.last)
                report_mismatch($sformatf("frame_last %0d, want %0d", last, want.last));
            if (length !== want.length)
                report_mismatch($sformatf("frame_length %0d, want %0d", length, want.length));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_stream_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_payload_byte;
    logic        m_frame_last;
    logic [31:0] m_frame_length;

    frame_tracker tracker;
    logic [7:0]   stream_q[$];
    int           sent_count;
    int           cycle_count;
    bit           tx_burst;
    bit           rx_burst;
    bit           hold_request;

    content_length_frame_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_stream_byte  (s_stream_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_last   (m_frame_last),
        .m_frame_length (m_frame_length)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_result(m_result_kind, m_payload_byte, m_frame_last, m_frame_length);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // result side: random stalls, bursts, and one long hold-off on request
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (rx_burst) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = (!tx_burst && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.take_byte(b);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_stream();
        while (stream_q.size() > 0) send_byte(stream_q.pop_front());
    endtask

    task automatic queue_byte(logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    // drop valid, drain expected results, then let the pipeline go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.due_tokens.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_max_len(logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.max_len = v;
    endtask

    function automatic string one_char(logic [7:0] b);
        return $sformatf("%c", b);
    endfunction

    function automatic string line_end(bit crlf);
        string s;
        if (crlf) s = "\015\n";
        else s = "\n";
        return s;
    endfunction

    function automatic string cased_key();
        string k;
        k = "content-length";
        for (int i = 0; i < k.len(); i++)
            if (k[i] >= "a" && k[i] <= "z" && $urandom_range(0, 1)) k[i] = k[i] - 8'd32;
        return k;
    endfunction

    function automatic string blanks();
        string s;
        s = "";
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
                0: s = {s, " "};
                1: s = {s, "\t"};
                2: s = {s, "\013"};
                3: s = {s, "\014"};
                default: s = {s, "\015"};
            endcase
        end
        return s;
    endfunction

    function automatic string trailer();
        string s;
        case ($urandom_range(0, 3))
            0: s = " ;q";
            1: s = "x7";
            2: s = blanks();
            default: s = "";
        endcase
        return s;
    endfunction

    function automatic string filler_line(bit crlf);
        string s;
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, one_char(8'($urandom_range(33, 126)))};
        if ($urandom_range(0, 3) != 0) begin
            s = {s, ":"};
            repeat ($urandom_range(0, 5)) s = {s, one_char(8'($urandom_range(32, 126)))};
        end
        return {s, line_end(crlf)};
    endfunction

    // one header block plus payload; mostly well formed, some broken or noise
    task automatic build_random_frame();
        int          r;
        int          n;
        int          cap;
        bit          crlf;
        logic [63:0] over;
        string       hdr;
        string       lead;
        string       odd;
        crlf = 1'($urandom_range(0, 1));
        r    = $urandom_range(0, 99);
        if (r >= 93) begin
            repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(0, 255)));
            return;
        end
        cap = (tracker.max_len < 6) ? int'(tracker.max_len) : 6;
        if (tracker.max_len >= 24 && $urandom_range(0, 7) == 0) cap = 24;
        n    = $urandom_range(0, cap);
        lead = "";
        if ($urandom_range(0, 3) == 0) lead = "0";
        hdr = "";
        repeat ($urandom_range(0, 2)) hdr = {hdr, filler_line(crlf)};
        // a blank value is skipped and a later length line still counts
        if (r >= 85) hdr = {hdr, cased_key(), ":", blanks(), line_end(crlf)};
        if (r < 60 || r >= 85) begin
            hdr = {hdr, cased_key(), ":", blanks(), lead, $sformatf("%0d", n), trailer(),
                   line_end(crlf)};
            if ($urandom_range(0, 3) == 0) hdr = {hdr, cased_key(), ":9", line_end(crlf)};
        end else if (r < 68) begin
            if ($urandom_range(0, 1)) hdr = {hdr, "content-length:", blanks(), line_end(crlf)};
        end else if (r < 77) begin
            odd = "+-a#.";
            hdr = {hdr, cased_key(), ":", blanks(), one_char(odd[$urandom_range(0, 4)]),
                   $sformatf("%0d", n), line_end(crlf)};
        end else begin
            over = {32'd0, tracker.max_len} + 64'd1 + $urandom_range(0, 1000);
            hdr  = {hdr, cased_key(), ":", blanks(), $sformatf("%0d", over), line_end(crlf)};
        end
        if ($urandom_range(0, 3) == 0) hdr = {hdr, filler_line(crlf)};
        hdr = {hdr, line_end(crlf && $urandom_range(0, 3) != 0)};
        push_text(hdr);
        if (r < 60 || r >= 85) repeat (n) queue_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [31:0] phase_limit [0:4];
        int          phase_start;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_stream_byte = '0;
        m_ready       = 1'b0;
        sent_count    = 0;
        cycle_count   = 0;
        tx_burst      = 0;
        rx_burst      = 0;
        hold_request  = 0;
        tracker       = new();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed cases at the reset limit
        push_text("Content-Length: 3\015\n\015\nabc");
        push_text("content-length:0\n\n");
        push_text("Host: x\n\n");
        push_text("content-length: -5\n\n");
        push_text("content-length:16777217\n\n");
        push_text("CONTENT-LENGTH: \t\013\014\ncontent-length: 2x9\n\n\n\n");
        push_text("content-length: 1\ncontent-length: 7\n\nZ");
        push_text("content\015-length:4\n\n");
        push_text("content-lengthx:1\ncontent-lengt:1\n\n");
        push_text("no colon here\ncontent-length:1\015\n\n");
        queue_byte(8'hFF);
        push_text("\n\n");
        push_text("content-length:007\015\n\015\n");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_byte(8'h7F);
        queue_byte(8'h01);
        queue_byte(8'h55);
        queue_byte(8'hAA);
        push_text("x:y:z\ncontent-length:\n\n");
        push_text("content-length:1 2\n\nQ");
        send_stream();

        settle();
        write_max_len(32'd0);
        push_text("content-length:0\n\ncontent-length:00\n\ncontent-length:1\n\n");
        send_stream();

        settle();
        write_max_len(32'hFFFF_FFFF);
        push_text("content-length:4294967296\n\n");
        push_text("content-length:99999999999999999999\n\n");
        push_text("content-length:2\n\nhi");
        send_stream();

        // hold the result side while a long payload is driven with no idle gaps
        settle();
        write_max_len(MAX_FRAME_LENGTH_RESET);
        hold_request = 1;
        tx_burst     = 1;
        push_text("content-length:40\n\n");
        repeat (40) queue_byte(8'($urandom_range(0, 255)));
        send_stream();
        tx_burst = 0;

        phase_limit[0] = 32'd5;
        phase_limit[1] = 32'hFFFF_FFFF;
        phase_limit[2] = 32'd0;
        phase_limit[3] = MAX_FRAME_LENGTH_RESET;
        phase_limit[4] = $urandom_range(1, 40);
        for (int p = 0; p < 5; p++) begin
            settle();
            write_max_len(phase_limit[p]);
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_BYTES) begin
                tx_burst = ($urandom_range(0, 4) == 0);
                rx_burst = ($urandom_range(0, 4) == 0);
                build_random_frame();
                send_stream();
            end
        end
        tx_burst = 0;
        rx_burst = 0;

        settle();
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
